// File: rtl/core/arcsine_branch_unit_defines.svh
// Assertion macros for the arcsine branch unit.
// Each macro expects clk and arst_n in scope.
`ifndef ARCSINE_BRANCH_UNIT_DEFINES_SVH
`define ARCSINE_BRANCH_UNIT_DEFINES_SVH

// Condition a implies condition c in the same cycle.
`define ASBU_ASSERT_IMPLY(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("arcsine branch unit: same-cycle check failed");

// Condition a implies condition c in the next cycle.
`define ASBU_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("arcsine branch unit: next-cycle check failed");

`endif

// File: rtl/core/asbu_pkg.sv
// ----------------------------------------------------------------------------
// asbu_pkg
// Constants, register codes and the arctangent table of the arcsine unit.
// ----------------------------------------------------------------------------
`default_nettype none

package asbu_pkg;

	localparam int WORK_FRAC = 30;

	// 57.29577951 * 2^24, rounded
	localparam logic signed [31:0] DEG_Q24 = 32'sd961263669;
	// pi * 2^30, rounded
	localparam logic [38:0] PI_Q30 = 39'd3373259426;
	// 180 * 2^30
	localparam logic [38:0] HALF_DEG_Q30 = 39'd193273528320;

	typedef enum logic {
		REG_DEGREE_MODE  = 1'b0,
		REG_BRANCH_INDEX = 1'b1
	} reg_index_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] t;
		unique case (i)
			5'd0:  t = 32'h3243F6A8;
			5'd1:  t = 32'h1DAC6705;
			5'd2:  t = 32'h0FADBAFC;
			5'd3:  t = 32'h07F56EA6;
			5'd4:  t = 32'h03FEAB76;
			5'd5:  t = 32'h01FFD55B;
			5'd6:  t = 32'h00FFFAAA;
			5'd7:  t = 32'h007FFF55;
			5'd8:  t = 32'h003FFFEA;
			5'd9:  t = 32'h001FFFFD;
			5'd10: t = 32'h000FFFFF;
			5'd11: t = 32'h0007FFFF;
			5'd12: t = 32'h0003FFFF;
			5'd13: t = 32'h0001FFFF;
			5'd14: t = 32'h0000FFFF;
			5'd15: t = 32'h00007FFF;
			5'd16: t = 32'h00003FFF;
			5'd17: t = 32'h00001FFF;
			5'd18: t = 32'h00000FFF;
			5'd19: t = 32'h000007FF;
			5'd20: t = 32'h000003FF;
			5'd21: t = 32'h000001FF;
			5'd22: t = 32'h000000FF;
			5'd23: t = 32'h0000007F;
			5'd24: t = 32'h0000003F;
			5'd25: t = 32'h0000001F;
			5'd26: t = 32'h0000000F;
			5'd27: t = 32'h00000007;
			5'd28: t = 32'h00000003;
			5'd29: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/arcsine_branch_unit.sv
// ----------------------------------------------------------------------------
// arcsine_branch_unit
// Pipelined arcsine with branch selection: floor square root, vectoring
// CORDIC, optional degree scaling and half-turn offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with operand_value (signed, FRACTION_BITS
//   fraction bits). Output channel: out_valid / out_stall with angle_value and
//   domain_error. Configuration through the APB-style port: degree_mode at
//   byte address 0, branch_index at byte address 4; write only while idle.
//   The pipeline holds one input stage, one squaring stage, 31 square-root
//   stages (one result bit each), one stage per CORDIC iteration, a degree
//   multiply stage, a branch multiply stage and the output register. One word
//   is accepted every cycle while in_stall is low.
//   When out_stall holds a valid result, the whole pipeline freezes and
//   in_stall rises; nothing is lost or repeated. Reset clears all valid bits
//   and both registers; the unit takes words right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module arcsine_branch_unit #(
	parameter int CORDIC_STAGES = 18,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [19:0] operand_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [32:0]      angle_value,
	output logic                    domain_error,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

`include "arcsine_branch_unit_defines.svh"

	localparam int SQ_STEPS = 31;
	localparam int SHIFT_IN = asbu_pkg::WORK_FRAC - FRACTION_BITS;

	// configuration
	logic       degree_mode_q;
	logic [7:0] branch_index_q;
	logic       cfg_wr;
	asbu_pkg::reg_index_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = asbu_pkg::reg_index_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_mode_q  <= 1'b0;
			branch_index_q <= 8'd0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				asbu_pkg::REG_DEGREE_MODE:  degree_mode_q  <= pwdata[0];
				asbu_pkg::REG_BRANCH_INDEX: branch_index_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			asbu_pkg::REG_DEGREE_MODE:  prdata = {31'd0, degree_mode_q};
			asbu_pkg::REG_BRANCH_INDEX: prdata = {24'd0, branch_index_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// global advance: freeze only when a finished word waits
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: range check, scale to Q30
	logic signed [25:0] x_ext;
	logic               x_err;
	logic               vl_s1, err_s1;
	logic signed [31:0] x30_s1;

	assign x_ext = 26'(operand_value);
	assign x_err = (x_ext > (26'sd1 <<< FRACTION_BITS)) ||
		(x_ext < -(26'sd1 <<< FRACTION_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vl_s1 <= 1'b0;
		else if (adv) vl_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= x_err;
			x30_s1 <= x_err ? 32'sd0 : (32'(operand_value) <<< SHIFT_IN);
		end
	end

	// stage 2: radicand 2^60 - x^2
	logic               vl_s2, err_s2;
	logic signed [31:0] x30_s2;
	logic [61:0]        rad_s2;
	logic signed [63:0] sq;

	assign sq = x30_s1 * x30_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vl_s2 <= 1'b0;
		else if (adv) vl_s2 <= vl_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2 <= err_s1;
			x30_s2 <= x30_s1;
			rad_s2 <= (62'd1 << 60) - sq[61:0];
		end
	end

	// square-root stages: one result bit each
	logic [61:0]        sqv_s3 [0:SQ_STEPS];
	logic [61:0]        sqr_s3 [0:SQ_STEPS];
	logic signed [31:0] sqx_s3 [0:SQ_STEPS];
	logic               sqe_s3 [0:SQ_STEPS];
	logic               sqvl_s3[0:SQ_STEPS];

	assign sqv_s3[0]  = rad_s2;
	assign sqr_s3[0]  = 62'd0;
	assign sqx_s3[0]  = x30_s2;
	assign sqe_s3[0]  = err_s2;
	assign sqvl_s3[0] = vl_s2;

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
		logic [61:0] trial;
		logic        ge;
		assign trial = sqr_s3[j] + BIT;
		assign ge    = sqv_s3[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqvl_s3[j+1] <= 1'b0;
			else if (adv) sqvl_s3[j+1] <= sqvl_s3[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sqv_s3[j+1] <= ge ? sqv_s3[j] - trial : sqv_s3[j];
				sqr_s3[j+1] <= ge ? (sqr_s3[j] >> 1) + BIT : sqr_s3[j] >> 1;
				sqx_s3[j+1] <= sqx_s3[j];
				sqe_s3[j+1] <= sqe_s3[j];
			end
		end
	end

	// vectoring CORDIC stages
	logic signed [35:0] cx_s4 [0:CORDIC_STAGES];
	logic signed [35:0] cy_s4 [0:CORDIC_STAGES];
	logic signed [31:0] cz_s4 [0:CORDIC_STAGES];
	logic               ce_s4 [0:CORDIC_STAGES];
	logic               cvl_s4[0:CORDIC_STAGES];

	assign cx_s4[0]  = 36'(signed'({1'b0, sqr_s3[SQ_STEPS][30:0]}));
	assign cy_s4[0]  = 36'(sqx_s3[SQ_STEPS]);
	assign cz_s4[0]  = 32'sd0;
	assign ce_s4[0]  = sqe_s3[SQ_STEPS];
	assign cvl_s4[0] = sqvl_s3[SQ_STEPS];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		localparam logic [31:0] ATAN = asbu_pkg::atan_q30(5'(i));
		logic signed [35:0] dx, dy;
		assign dx = cy_s4[i] >>> i;
		assign dy = cx_s4[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cvl_s4[i+1] <= 1'b0;
			else if (adv) cvl_s4[i+1] <= cvl_s4[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ce_s4[i+1] <= ce_s4[i];
				if (!cy_s4[i][35]) begin
					cx_s4[i+1] <= cx_s4[i] + dx;
					cy_s4[i+1] <= cy_s4[i] - dy;
					cz_s4[i+1] <= cz_s4[i] + signed'(ATAN);
				end else begin
					cx_s4[i+1] <= cx_s4[i] - dx;
					cy_s4[i+1] <= cy_s4[i] + dy;
					cz_s4[i+1] <= cz_s4[i] - signed'(ATAN);
				end
			end
		end
	end

	// stage 5: degree product
	logic               vl_s5, err_s5;
	logic signed [31:0] z_s5;
	logic signed [63:0] prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vl_s5 <= 1'b0;
		else if (adv) vl_s5 <= cvl_s4[CORDIC_STAGES];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s5  <= ce_s4[CORDIC_STAGES];
			z_s5    <= cz_s4[CORDIC_STAGES];
			prod_s5 <= cz_s4[CORDIC_STAGES] * asbu_pkg::DEG_Q24;
		end
	end

	// stage 6: round degrees, branch offset k * half turn
	logic               vl_s6, err_s6;
	logic signed [39:0] r_s6;
	logic [46:0]        kh_s6;
	logic signed [63:0] prod_rnd;
	logic [38:0]        half;

	assign prod_rnd = (prod_s5 + 64'sd8388608) >>> 24;
	assign half     = degree_mode_q ? asbu_pkg::HALF_DEG_Q30 : asbu_pkg::PI_Q30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vl_s6 <= 1'b0;
		else if (adv) vl_s6 <= vl_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s6 <= err_s5;
			r_s6   <= degree_mode_q ? prod_rnd[39:0] : 40'(z_s5);
			kh_s6  <= 47'(branch_index_q) * 47'(half);
		end
	end

	// output stage: sign by branch parity, round to output fraction
	logic signed [48:0] r_sel, acc, acc_rnd;

	assign r_sel   = branch_index_q[0] ? -49'(r_s6) : 49'(r_s6);
	assign acc     = r_sel + signed'({2'b00, kh_s6});
	assign acc_rnd = (acc + (49'sd1 <<< (SHIFT_IN - 1))) >>> SHIFT_IN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vl_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			domain_error <= err_s6;
			angle_value  <= err_s6 ? 33'sd0 : acc_rnd[32:0];
		end
	end

	`ASBU_ASSERT_IMPLY(a_err_zero, out_valid && domain_error, angle_value == 33'sd0)
	`ASBU_ASSERT_IMPLY(a_stall_freeze, out_valid && out_stall, in_stall)
	`ASBU_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(angle_value))

endmodule

`default_nettype wire
